### sv/sfb_pkg.sv
// Shared types and constants of the seam feather blender.
// No dependencies; imported by every module of the block.
package sfb_pkg;

	localparam int unsigned MAX_COLUMNS_DEF  = 4096;
	localparam int unsigned WEIGHT_FRAC_DEF  = 16;

	localparam int unsigned CHAN_W           = 8;
	localparam int unsigned START_W          = 12;
	localparam int unsigned LEFT_WIDTH_W     = 13;
	localparam int unsigned INV_W            = 17;
	localparam int unsigned CFG_DATA_W       = 17;
	localparam int unsigned CFG_INDEX_W      = 2;
	localparam int unsigned PROD_W           = LEFT_WIDTH_W + INV_W;

	localparam logic [CFG_INDEX_W-1:0] REG_OVERLAP_START   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LEFT_WIDTH      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_OVERLAP = 2'd2;

	localparam logic [START_W-1:0]      OVERLAP_START_RST   = 12'd0;
	localparam logic [LEFT_WIDTH_W-1:0] LEFT_WIDTH_RST      = 13'd4096;
	localparam logic [INV_W-1:0]        INVERSE_OVERLAP_RST = 17'd16;

	typedef enum logic [1:0] {
		RGN_LEFT,
		RGN_BLEND,
		RGN_WARP
	} region_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

	typedef struct packed {
		region_t region;
		logic    row_end;
	} ctl_t;

endpackage

### sv/seam_feather_blend_core.sv
// Top level of the seam feather blender: stream ports, register file, pipeline.
// Depends on sfb_pkg, sfb_weight, sfb_lane and sfb_merge.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-------------------------------------
//  s_axis    | in        | tvalid / tready        | tdata: left rgb, warp rgb; tlast: row end
//  m_axis    | out       | tvalid / tready        | tdata: stitched rgb; tlast: row end
//  cfg       | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
// One pixel pair per clock while the output side takes transfers. An input transfer
// passes the weight stage, lane multiply and merge register before output valid.
// The whole pipeline advances together; it holds while a result waits unclaimed in
// the output register, and a bubble in that register lets the next transfer in.
// Reset clears the column counter, valid flags and configuration registers to their defaults.
module seam_feather_blend_core import sfb_pkg::*; #(
	parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int unsigned WEIGHT_FRAC = WEIGHT_FRAC_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// left_red, left_green, left_blue, warp_red, warp_green, warp_blue (low to high)
	input  logic [47:0]            s_axis_tdata,
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_red, out_green, out_blue (low to high)
	output logic [23:0]            m_axis_tdata,
	output logic                   m_axis_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [START_W-1:0]      overlap_start_q;
	logic [LEFT_WIDTH_W-1:0] left_width_q;
	logic [INV_W-1:0]        inverse_overlap_q;

	logic   adv;
	logic   accept;
	logic   v_s1_q;
	logic   v_s2_q;
	logic   out_valid_q;
	rgb_t   left_in;
	rgb_t   warp_in;
	logic   warp_black;
	rgb_t   left_s1;
	rgb_t   warp_s1;
	rgb_t   left_s2;
	rgb_t   warp_s2;
	ctl_t   ctl_s1;
	ctl_t   ctl_s2;
	rgb_t   mix_s2;
	rgb_t   out_pix_q;
	logic   out_row_end_q;
	logic [WEIGHT_FRAC:0] alpha_s1;

	// advance when the output register is empty or its transfer completes
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;

	assign left_in = '{red: s_axis_tdata[7:0], green: s_axis_tdata[15:8],
		blue: s_axis_tdata[23:16]};
	assign warp_in = '{red: s_axis_tdata[31:24], green: s_axis_tdata[39:32],
		blue: s_axis_tdata[47:40]};
	assign warp_black = (warp_in == '0);

	// register file; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlap_start_q   <= OVERLAP_START_RST;
			left_width_q      <= LEFT_WIDTH_RST;
			inverse_overlap_q <= INVERSE_OVERLAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OVERLAP_START:   overlap_start_q   <= cfg_data[START_W-1:0];
				REG_LEFT_WIDTH:      left_width_q      <= cfg_data[LEFT_WIDTH_W-1:0];
				REG_INVERSE_OVERLAP: inverse_overlap_q <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	// valid flags move in lockstep with the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1_q      <= accept;
			v_s2_q      <= v_s1_q;
			out_valid_q <= v_s2_q;
		end
	end

	// pixels ride alongside for the pass-through regions
	always_ff @(posedge clk) begin
		if (adv) begin
			left_s1 <= left_in;
			warp_s1 <= warp_in;
			left_s2 <= left_s1;
			warp_s2 <= warp_s1;
			ctl_s2  <= ctl_s1;
		end
	end

	sfb_weight #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.WEIGHT_FRAC (WEIGHT_FRAC)
	) u_weight (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.accept          (accept),
		.row_end         (s_axis_tlast),
		.warp_black      (warp_black),
		.overlap_start   (overlap_start_q),
		.left_width      (left_width_q),
		.inverse_overlap (inverse_overlap_q),
		.ctl_s1          (ctl_s1),
		.alpha_s1        (alpha_s1)
	);

	// one lane per colour channel
	sfb_lane #(.WEIGHT_FRAC(WEIGHT_FRAC)) u_lane_red (
		.clk       (clk),
		.adv       (adv),
		.left_chan (left_s1.red),
		.warp_chan (warp_s1.red),
		.alpha     (alpha_s1),
		.mix_s2    (mix_s2.red)
	);

	sfb_lane #(.WEIGHT_FRAC(WEIGHT_FRAC)) u_lane_green (
		.clk       (clk),
		.adv       (adv),
		.left_chan (left_s1.green),
		.warp_chan (warp_s1.green),
		.alpha     (alpha_s1),
		.mix_s2    (mix_s2.green)
	);

	sfb_lane #(.WEIGHT_FRAC(WEIGHT_FRAC)) u_lane_blue (
		.clk       (clk),
		.adv       (adv),
		.left_chan (left_s1.blue),
		.warp_chan (warp_s1.blue),
		.alpha     (alpha_s1),
		.mix_s2    (mix_s2.blue)
	);

	sfb_merge u_merge (
		.clk           (clk),
		.adv           (adv),
		.ctl           (ctl_s2),
		.left_pix      (left_s2),
		.warp_pix      (warp_s2),
		.mix_pix       (mix_s2),
		.out_pix_q     (out_pix_q),
		.out_row_end_q (out_row_end_q)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_pix_q.blue, out_pix_q.green, out_pix_q.red};
	assign m_axis_tlast  = out_row_end_q;

endmodule

### sv/sfb_weight.sv
// Column tracker and left-weight stage of the seam feather blender.
// Depends on sfb_pkg; feeds the lanes with a registered weight.
module sfb_weight import sfb_pkg::*; #(
	parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int unsigned WEIGHT_FRAC = WEIGHT_FRAC_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    accept,
	input  logic                    row_end,
	input  logic                    warp_black,
	input  logic [START_W-1:0]      overlap_start,
	input  logic [LEFT_WIDTH_W-1:0] left_width,
	input  logic [INV_W-1:0]        inverse_overlap,
	output ctl_t                    ctl_s1,
	output logic [WEIGHT_FRAC:0]    alpha_s1
);

	localparam int unsigned CW   = $clog2(MAX_COLUMNS);
	localparam int unsigned CMPW = (CW > LEFT_WIDTH_W) ? CW : LEFT_WIDTH_W;
	localparam int unsigned AW   = WEIGHT_FRAC + 1;
	localparam logic [PROD_W-1:0] ONE_P = PROD_W'(1) << WEIGHT_FRAC;
	localparam logic [CW-1:0]     LAST_COL = CW'(MAX_COLUMNS - 1);

	logic [CW-1:0]           col_q;
	logic [CMPW-1:0]         col_x;
	logic [CMPW-1:0]         lw_x;
	logic [CMPW-1:0]         st_x;
	logic [CMPW-1:0]         diff;
	logic [PROD_W-1:0]       prod;
	logic [AW-1:0]           alpha;
	region_t                 region;

	assign col_x = CMPW'(col_q);
	assign lw_x  = CMPW'(left_width);
	assign st_x  = CMPW'(overlap_start);
	assign diff  = lw_x - col_x;
	assign prod  = PROD_W'(diff[LEFT_WIDTH_W-1:0]) * PROD_W'(inverse_overlap);

	always_comb begin
		if (col_x >= lw_x) begin
			region = RGN_WARP;
		end else if (col_x < st_x) begin
			region = RGN_LEFT;
		end else begin
			region = RGN_BLEND;
		end
		// black warped pixel or overshoot: full left weight
		if (warp_black || (prod > ONE_P)) begin
			alpha = ONE_P[AW-1:0];
		end else begin
			alpha = prod[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (accept) begin
			if (row_end || (col_q == LAST_COL)) begin
				col_q <= '0;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1.region  <= region;
			ctl_s1.row_end <= row_end;
			alpha_s1       <= alpha;
		end
	end

endmodule

### sv/sfb_lane.sv
// One colour channel mixer of the seam feather blender.
// Depends on sfb_pkg; three copies run side by side.
module sfb_lane import sfb_pkg::*; #(
	parameter int unsigned WEIGHT_FRAC = WEIGHT_FRAC_DEF
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic [CHAN_W-1:0]    left_chan,
	input  logic [CHAN_W-1:0]    warp_chan,
	input  logic [WEIGHT_FRAC:0] alpha,
	output logic [CHAN_W-1:0]    mix_s2
);

	localparam int unsigned AW   = WEIGHT_FRAC + 1;
	localparam int unsigned ACCW = CHAN_W + AW;
	localparam logic [AW-1:0] ONE_A = AW'(1) << WEIGHT_FRAC;

	logic [AW-1:0]   beta;
	logic [ACCW-1:0] acc;

	assign beta = ONE_A - alpha;
	assign acc  = ACCW'(left_chan) * ACCW'(alpha) + ACCW'(warp_chan) * ACCW'(beta);

	always_ff @(posedge clk) begin
		if (adv) begin
			mix_s2 <= acc[WEIGHT_FRAC+CHAN_W-1:WEIGHT_FRAC];
		end
	end

endmodule

### sv/sfb_merge.sv
// Merge stage of the seam feather blender: picks left, warped or mixed pixel.
// Depends on sfb_pkg; drives the output register.
module sfb_merge import sfb_pkg::*; (
	input  logic clk,
	input  logic adv,
	input  ctl_t ctl,
	input  rgb_t left_pix,
	input  rgb_t warp_pix,
	input  rgb_t mix_pix,
	output rgb_t out_pix_q,
	output logic out_row_end_q
);

	rgb_t sel;

	always_comb begin
		unique case (ctl.region)
			RGN_LEFT:  sel = left_pix;
			RGN_BLEND: sel = mix_pix;
			RGN_WARP:  sel = warp_pix;
			default:   sel = warp_pix;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pix_q     <= sel;
			out_row_end_q <= ctl.row_end;
		end
	end

endmodule
